// ----- rtl/b2d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_pkg
// Shared widths, constants and types for the binary to decimal ASCII core.
// ----------------------------------------------------------------------------
package b2d_pkg;

	localparam int VALUE_W      = 64;
	localparam int NDIGITS      = 20;
	localparam int BCD_W        = 4 * NDIGITS;
	localparam int CNT_W        = 5;
	localparam int CHAR_W       = 6;
	localparam int IDX_W        = 5;
	localparam int BIT_W        = 6;
	localparam int QDEPTH       = 2;
	localparam int PTR_W        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int FILL_W       = $clog2(QDEPTH + 1);

	localparam logic [BIT_W-1:0]  LAST_SHIFT = BIT_W'(VALUE_W - 1);
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
	localparam logic [CHAR_W-1:0] ASCII_NINE = 6'd57;
	localparam logic [CNT_W-1:0]  MIN_COUNT  = 5'd1;
	localparam logic [CNT_W-1:0]  MAX_COUNT  = CNT_W'(NDIGITS);

	// one converted value waiting for emission
	typedef struct packed {
		logic [BCD_W-1:0] bcd;
		logic [CNT_W-1:0] count;
	} b2d_entry_t;

	typedef struct packed {
		logic       valid;
		b2d_entry_t entry;
	} b2d_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} b2d_qstat_t;

endpackage

// ----- rtl/b2d_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_front
// Takes a value, converts it to packed BCD by shift-and-add-3 one bit per
// cycle, counts significant digits and hands the result to the queue.
// ----------------------------------------------------------------------------
module b2d_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [b2d_pkg::VALUE_W-1:0] value,
	input  b2d_pkg::b2d_qstat_t     qstat,
	output logic                    busy,
	output b2d_pkg::b2d_push_t      push
);
	import b2d_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SHIFT = 2'd1;
	localparam logic [1:0] ST_COUNT = 2'd2;

	logic [1:0]         state_q;
	logic [VALUE_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [BIT_W-1:0]   bit_q;
	logic [BCD_W-1:0]   bcd_adj;
	logic [CNT_W-1:0]   cnt;

	// add three to every digit of five or more ahead of the shift
	always_comb begin
		for (int i = 0; i < NDIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// highest non-zero digit sets the count; zero still gives one digit
	always_comb begin
		cnt = MIN_COUNT;
		for (int i = 0; i < NDIGITS; i++) begin
			if (bcd_q[4*i +: 4] != 4'd0) begin
				cnt = CNT_W'(i + 1);
			end
		end
	end

	assign busy             = (state_q != ST_IDLE);
	assign push.valid       = (state_q == ST_COUNT) && !qstat.full;
	assign push.entry.bcd   = bcd_q;
	assign push.entry.count = cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			bit_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SHIFT;
						bit_q   <= '0;
					end
				end
				ST_SHIFT: begin
					if (bit_q == LAST_SHIFT) begin
						state_q <= ST_COUNT;
					end else begin
						bit_q <= bit_q + 1'b1;
					end
				end
				ST_COUNT: begin
					if (!qstat.full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (state_q == ST_SHIFT) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
		end
	end

endmodule

// ----- rtl/b2d_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_queue
// Short FIFO of converted values between the front and back parts.
// ----------------------------------------------------------------------------
module b2d_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  b2d_pkg::b2d_push_t   push,
	input  logic                 pop,
	output b2d_pkg::b2d_entry_t  head,
	output b2d_pkg::b2d_qstat_t  qstat
);
	import b2d_pkg::*;

	b2d_entry_t        mem_q [QDEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	assign qstat.full  = (fill_q == FILL_W'(QDEPTH));
	assign qstat.empty = (fill_q == '0);
	assign head        = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push.valid) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !qstat.full)
		else $error("transfer into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qstat.empty)
		else $error("pop from empty queue");

endmodule

// ----- rtl/b2d_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2d_back
// Pops converted values and emits their digits, most significant first.
// ----------------------------------------------------------------------------
module b2d_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  b2d_pkg::b2d_entry_t         head,
	input  b2d_pkg::b2d_qstat_t         qstat,
	output logic                        pop,
	output logic                        digit_strobe,
	output logic [b2d_pkg::CHAR_W-1:0]  digit_char,
	output logic [b2d_pkg::CNT_W-1:0]   digit_count,
	output logic                        last_digit
);
	import b2d_pkg::*;

	logic             emit_q;
	b2d_entry_t       entry_q;
	logic [IDX_W-1:0] idx_q;
	logic [3:0]       nib;

	assign pop = !emit_q && !qstat.empty;
	assign nib = entry_q.bcd[{idx_q, 2'b00} +: 4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q       <= 1'b0;
			digit_strobe <= 1'b0;
		end else begin
			digit_strobe <= emit_q;
			if (emit_q) begin
				if (idx_q == '0) begin
					emit_q <= 1'b0;
				end
			end else if (!qstat.empty) begin
				emit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit_q) begin
			idx_q       <= idx_q - 1'b1;
			digit_char  <= ASCII_ZERO + {2'b00, nib};
			digit_count <= entry_q.count;
			last_digit  <= (idx_q == '0);
		end else if (!qstat.empty) begin
			entry_q <= head;
			idx_q   <= IDX_W'(head.count - 1'b1);
		end
	end

	a_char_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit_strobe |-> (digit_char >= ASCII_ZERO) && (digit_char <= ASCII_NINE))
		else $error("digit character out of range");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit_strobe |-> (digit_count >= MIN_COUNT) && (digit_count <= MAX_COUNT))
		else $error("digit count out of range");

	a_run_unbroken: assert property (@(posedge clk) disable iff (!arst_n)
		digit_strobe && !last_digit |=> digit_strobe && $stable(digit_count))
		else $error("digit run broken before its last digit");

endmodule

// ----- rtl/binary_to_decimal_ascii_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Unsigned 64-bit value to decimal ASCII digits, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive value and raise start; the transfer happens on the edge
//   where start is high and busy is low. busy stays high while the front
//   part converts, so hold start until busy is seen low.
//   Output: one digit per cycle, each shown for a single cycle with
//   digit_strobe high. digit_count is the same on every digit of a run and
//   last_digit marks the least significant digit. Zero gives one '0'.
//   Path: a value passes the bit-serial shift, the digit count state, the
//   queue, the back part's entry register and the registered digit
//   outputs before its first digit appears.
//   Pacing: the front hands each value to the queue after the 64-step BCD
//   shift loop and only then takes the next; the back part emits up to 20
//   digits meanwhile from a two-entry queue, so it never holds the front up.
//   Reset: arst_n clears the controllers and empties the queue; no digit
//   is shown afterwards until a new value is taken.
//   Stalls: the receiver cannot stall; every digit must be taken when shown.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [b2d_pkg::VALUE_W-1:0] value,
	output logic                        digit_strobe,
	output logic [b2d_pkg::CHAR_W-1:0]  digit_char,
	output logic [b2d_pkg::CNT_W-1:0]   digit_count,
	output logic                        last_digit
);
	import b2d_pkg::*;

	b2d_push_t  push;
	b2d_qstat_t qstat;
	b2d_entry_t head;
	logic       pop;

	// front: take the value, convert to BCD, count digits, hand to queue
	b2d_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.value  (value),
		.qstat  (qstat),
		.busy   (busy),
		.push   (push)
	);

	// queue: decouple conversion from emission
	b2d_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	// back: walk the digits from the top one down, one per cycle
	b2d_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.qstat        (qstat),
		.pop          (pop),
		.digit_strobe (digit_strobe),
		.digit_char   (digit_char),
		.digit_count  (digit_count),
		.last_digit   (last_digit)
	);

endmodule
